// ----- sv/size_class_cell_allocator_assert.svh -----
// Assertion shorthands shared by the allocator modules.
`ifndef SIZE_CLASS_CELL_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_CELL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SCCA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, ignored while reset is high.
`define SCCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

// ----- sv/scca_pkg.sv -----
`default_nettype none
package scca_pkg;

   localparam int SCCA_MAX_BLOCKS = 8;
   localparam int BLOCK_BYTES     = 4096;
   localparam int MIN_CELL_BYTES  = 16;

   localparam int REQ_W      = 13;
   localparam int CELL_W     = 8;
   localparam int LINK_W     = 9;
   localparam int TOTAL_W    = 9;
   localparam int CELLS_CAP  = 256;
   localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(256);

   // Quotient width of BLOCK_BYTES / cell size, one bit per divider step
   localparam int DIV_W = $clog2(BLOCK_BYTES + 1);
   localparam int DIV_IDX_W = $clog2(DIV_W);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT,
      ST_LINK,
      ST_DIV,
      ST_CREATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_SLOT   = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_BAD_FREE  = 2'd3
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       scan;
      logic       push;
      logic       link_read;
      logic       pop;
      logic       take_fresh;
      logic       div_start;
      logic       div_step;
      logic       create;
      logic       load;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic oversize;
      logic bad_free;
      logic hit;
      logic head_empty;
      logic full;
      logic div_last;
      logic out_busy;
   } stat_type;

endpackage
`default_nettype wire

// ----- sv/size_class_cell_allocator.sv -----
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------------------------
// request  | req_valid / req_ready | req_mode, req_request_bytes, req_free_block,
//          |                       | req_free_cell
// response | rsp_valid / rsp_ready | rsp_status, rsp_got_block, rsp_got_cell,
//          |                       | rsp_made_block
//
// One item at a time. A free, a rejected request or an allocation from a block with
// no freed cells passes through the scan, act and done states; a pop from a freed
// list adds a link state for the registered read of the link memory. Creating a
// block adds the bit-serial divider that sizes its cell count and a create state.
// Reset clears the block count, the state machine and the response valid; no sweep.
// A stalled response is held in its register; the next request is still accepted
// and waits before its own response is loaded.
`default_nettype none
module size_class_cell_allocator #(
   parameter int MAX_BLOCKS = scca_pkg::SCCA_MAX_BLOCKS,
   parameter int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_mode,
   input  wire logic [scca_pkg::REQ_W-1:0]  req_request_bytes,
   input  wire logic [BLK_W-1:0]            req_free_block,
   input  wire logic [scca_pkg::CELL_W-1:0] req_free_cell,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [BLK_W-1:0]                 rsp_got_block,
   output logic [scca_pkg::CELL_W-1:0]      rsp_got_cell,
   output logic                             rsp_made_block
);
   import scca_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   scca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   scca_dp #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .BLK_W      (BLK_W)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_request_bytes (req_request_bytes),
      .req_free_block    (req_free_block),
      .req_free_cell     (req_free_cell),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_got_block     (rsp_got_block),
      .rsp_got_cell      (rsp_got_cell),
      .rsp_made_block    (rsp_made_block)
   );

endmodule
`default_nettype wire

// ----- sv/scca_ctrl.sv -----
`default_nettype none
module scca_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire scca_pkg::stat_type stat,
   output scca_pkg::cmd_type      cmd
);
   import scca_pkg::*;

   `include "size_class_cell_allocator_assert.svh"

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         code_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      cmd       = '0;
      cmd.code  = code_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               code_in     = STATUS_OK;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            state_in = ST_ACT;
         end
         ST_ACT: begin
            state_in = ST_DONE;
            priority if (stat.is_free) begin
               if (stat.bad_free) begin
                  code_in = STATUS_BAD_FREE;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (stat.oversize) begin
               code_in = STATUS_TOO_LARGE;
            end else if (stat.hit) begin
               if (stat.head_empty) begin
                  cmd.take_fresh = 1'b1;
               end else begin
                  cmd.link_read = 1'b1;
                  state_in      = ST_LINK;
               end
            end else if (stat.full) begin
               code_in = STATUS_NO_SLOT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_LINK: begin
            cmd.pop  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_CREATE;
            end
         end
         ST_CREATE: begin
            cmd.create = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!stat.out_busy) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SCCA_ASSERT_NOW(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.capture, cmd.scan, cmd.push, cmd.link_read, cmd.pop, cmd.take_fresh, cmd.div_start, cmd.div_step, cmd.create, cmd.load}))
   `SCCA_ASSERT_NEXT(a_link_then_pop, clock, reset, cmd.link_read, cmd.pop)
   `SCCA_ASSERT_NOW(a_create_after_div, clock, reset, cmd.create, $past(cmd.div_step))
   `SCCA_ASSERT_NOW(a_load_free_slot, clock, reset, cmd.load, !stat.out_busy)

endmodule
`default_nettype wire

// ----- sv/scca_dp.sv -----
`default_nettype none
module scca_dp #(
   parameter int MAX_BLOCKS = scca_pkg::SCCA_MAX_BLOCKS,
   parameter int BLK_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire scca_pkg::cmd_type          cmd,
   output scca_pkg::stat_type              stat,
   input  wire logic                       req_mode,
   input  wire logic [scca_pkg::REQ_W-1:0] req_request_bytes,
   input  wire logic [BLK_W-1:0]           req_free_block,
   input  wire logic [scca_pkg::CELL_W-1:0] req_free_cell,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_status,
   output logic [BLK_W-1:0]                rsp_got_block,
   output logic [scca_pkg::CELL_W-1:0]     rsp_got_cell,
   output logic                            rsp_made_block
);
   import scca_pkg::*;

   `include "size_class_cell_allocator_assert.svh"

   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int ADDR_W  = BLK_W + CELL_W;
   localparam int DEPTH   = MAX_BLOCKS * CELLS_CAP;
   localparam logic [DIV_W-1:0] DIVIDEND = DIV_W'(BLOCK_BYTES);

   // captured request
   logic              mode_ff;
   logic [REQ_W-1:0]  req_bytes_ff;
   logic [BLK_W-1:0]  free_block_ff;
   logic [CELL_W-1:0] free_cell_ff;

   // per-block descriptors, meaningful below blocks_ff only
   logic [CNT_W-1:0]   blocks_ff;
   logic [REQ_W-1:0]   cell_bytes_ff [MAX_BLOCKS];
   logic [TOTAL_W-1:0] cell_total_ff [MAX_BLOCKS];
   logic [LINK_W-1:0]  head_ff       [MAX_BLOCKS];
   logic [TOTAL_W-1:0] fresh_ff      [MAX_BLOCKS];

   logic [LINK_W-1:0]  link_mem [DEPTH];
   logic [LINK_W-1:0]  link_rd_ff;

   logic [BLK_W-1:0]   sel_ff, sel_in;
   logic               hit_ff, hit_in;
   logic [CELL_W-1:0]  gc_ff;
   logic               made_ff;

   logic [REQ_W-1:0]     divisor_ff;
   logic [REQ_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_IDX_W-1:0] idx_ff;
   logic [REQ_W:0]       trial;
   logic [REQ_W:0]       diff;
   logic                 trial_ge;
   logic [TOTAL_W-1:0]   new_total;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [BLK_W-1:0]     rsp_block_ff;
   logic [CELL_W-1:0]    rsp_cell_ff;
   logic                 rsp_made_ff;

   logic [MAX_BLOCKS-1:0] slot_ok;
   logic [LINK_W-1:0]     head_sel;
   logic [TOTAL_W-1:0]    fresh_sel;
   logic [TOTAL_W-1:0]    total_sel;

   assign head_sel  = head_ff[sel_ff];
   assign fresh_sel = fresh_ff[sel_ff];
   assign total_sel = cell_total_ff[sel_ff];

   // compare every slot at once, first in creation order wins
   always_comb begin
      for (int b = 0; b < MAX_BLOCKS; b++) begin
         slot_ok[b] = (CNT_W'(b) < blocks_ff) && (req_bytes_ff <= cell_bytes_ff[b]) &&
                      ((head_ff[b] != EMPTY_MARK) || (fresh_ff[b] < cell_total_ff[b]));
      end
      hit_in = |slot_ok;
      sel_in = '0;
      for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
         if (slot_ok[b]) begin
            sel_in = BLK_W'(b);
         end
      end
      if (mode_ff) begin
         sel_in = free_block_ff;
      end
   end

   // restoring division of the block size by the cell size, one bit a step
   assign trial     = {rem_ff, DIVIDEND[idx_ff]};
   assign trial_ge  = trial >= {1'b0, divisor_ff};
   assign diff      = trial - {1'b0, divisor_ff};
   assign new_total = (quo_ff > DIV_W'(CELLS_CAP)) ? TOTAL_W'(CELLS_CAP)
                                                 : quo_ff[TOTAL_W-1:0];

   always_comb begin
      stat            = '0;
      stat.is_free    = mode_ff;
      stat.oversize   = req_bytes_ff > REQ_W'(BLOCK_BYTES);
      stat.bad_free   = (CNT_W'(sel_ff) >= blocks_ff) ||
                        ({1'b0, free_cell_ff} >= total_sel);
      stat.hit        = hit_ff;
      stat.head_empty = (head_sel == EMPTY_MARK);
      stat.full       = (blocks_ff == CNT_W'(MAX_BLOCKS));
      stat.div_last   = (idx_ff == '0);
      stat.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.create) begin
            blocks_ff <= blocks_ff + CNT_W'(1);
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff       <= req_mode;
         req_bytes_ff  <= req_request_bytes;
         free_block_ff <= req_free_block;
         free_cell_ff  <= req_free_cell;
         made_ff       <= 1'b0;
      end
      if (cmd.scan) begin
         sel_ff <= sel_in;
         hit_ff <= hit_in;
      end
      if (cmd.push) begin
         link_mem[ADDR_W'({sel_ff, free_cell_ff})] <= head_sel;
         head_ff[sel_ff] <= {1'b0, free_cell_ff};
      end
      if (cmd.link_read) begin
         link_rd_ff <= link_mem[ADDR_W'({sel_ff, head_sel[CELL_W-1:0]})];
         gc_ff      <= head_sel[CELL_W-1:0];
      end
      if (cmd.pop) begin
         head_ff[sel_ff] <= link_rd_ff;
      end
      if (cmd.take_fresh) begin
         gc_ff            <= fresh_sel[CELL_W-1:0];
         fresh_ff[sel_ff] <= fresh_sel + TOTAL_W'(1);
      end
      if (cmd.div_start) begin
         divisor_ff <= (req_bytes_ff < REQ_W'(MIN_CELL_BYTES)) ? REQ_W'(MIN_CELL_BYTES)
                                                               : req_bytes_ff;
         rem_ff     <= '0;
         quo_ff     <= '0;
         idx_ff     <= DIV_IDX_W'(DIV_W - 1);
      end
      if (cmd.div_step) begin
         rem_ff         <= trial_ge ? diff[REQ_W-1:0] : trial[REQ_W-1:0];
         quo_ff[idx_ff] <= trial_ge;
         idx_ff         <= idx_ff - DIV_IDX_W'(1);
      end
      if (cmd.create) begin
         // new block hands out cell 0 straight away
         cell_bytes_ff[blocks_ff[BLK_W-1:0]] <= divisor_ff;
         cell_total_ff[blocks_ff[BLK_W-1:0]] <= new_total;
         head_ff[blocks_ff[BLK_W-1:0]]       <= EMPTY_MARK;
         fresh_ff[blocks_ff[BLK_W-1:0]]      <= TOTAL_W'(1);
         sel_ff  <= blocks_ff[BLK_W-1:0];
         gc_ff   <= '0;
         made_ff <= 1'b1;
      end
      if (cmd.load) begin
         rsp_status_ff <= cmd.code;
         if ((cmd.code == STATUS_OK) && !mode_ff) begin
            rsp_block_ff <= sel_ff;
            rsp_cell_ff  <= gc_ff;
            rsp_made_ff  <= made_ff;
         end else begin
            rsp_block_ff <= '0;
            rsp_cell_ff  <= '0;
            rsp_made_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_got_block  = rsp_block_ff;
   assign rsp_got_cell   = rsp_cell_ff;
   assign rsp_made_block = rsp_made_ff;

   `SCCA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, blocks_ff <= CNT_W'(MAX_BLOCKS))
   `SCCA_ASSERT_NEXT(a_create_grows, clock, reset, cmd.create, blocks_ff == $past(blocks_ff) + CNT_W'(1))
   `SCCA_ASSERT_NOW(a_fresh_in_range, clock, reset, cmd.take_fresh, fresh_sel < total_sel)
   `SCCA_ASSERT_NOW(a_create_has_room, clock, reset, cmd.create, !stat.full && (new_total != '0))

endmodule
`default_nettype wire

// ----- test/tb_size_class_cell_allocator.sv -----
`timescale 1ns / 1ps

module tb_size_class_cell_allocator;

   import scca_pkg::*;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } req_mode_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  blk;
      logic [7:0]  cell_idx;
      logic        made;
   } grant_type;

   typedef struct packed {
      logic [2:0]  blk;
      logic [7:0]  cell_idx;
   } cell_ref_type;

   class cell_ledger;
      int unsigned       blocks_made;
      int unsigned       cell_bytes [SCCA_MAX_BLOCKS];
      int unsigned       cell_total [SCCA_MAX_BLOCKS];
      logic [LINK_W-1:0] list_head  [SCCA_MAX_BLOCKS];
      int unsigned       fresh_next [SCCA_MAX_BLOCKS];
      logic [LINK_W-1:0] link_mem   [SCCA_MAX_BLOCKS * CELLS_CAP];
      grant_type         grants_due [$];
      int unsigned       mismatches;

      function new();
         blocks_made = 0;
         mismatches  = 0;
         for (int b = 0; b < SCCA_MAX_BLOCKS; b++) begin
            cell_bytes[b] = 0;
            cell_total[b] = 0;
            list_head[b]  = EMPTY_MARK;
            fresh_next[b] = 0;
         end
      endfunction

      function int unsigned pending();
         return grants_due.size();
      endfunction

      // Freed cells first, most recent first; then never-used cells in order.
      function logic [7:0] pop_cell(int unsigned b);
         logic [7:0] c;
         if (list_head[b] != EMPTY_MARK) begin
            c = list_head[b][7:0];
            list_head[b] = link_mem[b * CELLS_CAP + c];
         end else begin
            c = fresh_next[b][7:0];
            fresh_next[b]++;
         end
         return c;
      endfunction

      function grant_type note_request(req_mode_type mode, logic [REQ_W-1:0] bytes,
                                       logic [2:0] fb, logic [7:0] fc);
         grant_type   g;
         bit          found;
         int unsigned size;
         int unsigned count;
         g = '0;
         g.status = STATUS_OK;
         if (mode == MODE_FREE) begin
            if (fb >= blocks_made || fc >= cell_total[fb]) begin
               g.status = STATUS_BAD_FREE;
            end else begin
               link_mem[fb * CELLS_CAP + fc] = list_head[fb];
               list_head[fb] = {1'b0, fc};
            end
         end else if (bytes > BLOCK_BYTES) begin
            g.status = STATUS_TOO_LARGE;
         end else begin
            found = 1'b0;
            for (int unsigned b = 0; b < blocks_made; b++) begin
               if (!found && bytes <= cell_bytes[b] &&
                   (list_head[b] != EMPTY_MARK || fresh_next[b] < cell_total[b])) begin
                  found      = 1'b1;
                  g.blk      = b[2:0];
                  g.cell_idx = pop_cell(b);
               end
            end
            if (!found) begin
               if (blocks_made >= SCCA_MAX_BLOCKS) begin
                  g.status = STATUS_NO_SLOT;
               end else begin
                  size  = (bytes < MIN_CELL_BYTES) ? MIN_CELL_BYTES : bytes;
                  count = BLOCK_BYTES / size;
                  if (count > CELLS_CAP) count = CELLS_CAP;
                  cell_bytes[blocks_made] = size;
                  cell_total[blocks_made] = count;
                  list_head[blocks_made]  = EMPTY_MARK;
                  fresh_next[blocks_made] = 0;
                  g.blk      = blocks_made[2:0];
                  g.cell_idx = pop_cell(blocks_made);
                  g.made     = 1'b1;
                  blocks_made++;
               end
            end
         end
         grants_due.push_back(g);
         return g;
      endfunction

      function void check_grant(logic [1:0] status, logic [2:0] blk, logic [7:0] cell_idx,
                                logic made);
         grant_type g;
         if (grants_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: response with none outstanding: status %0d block %0d cell %0d",
                        $realtime, status, blk, cell_idx);
            return;
         end
         g = grants_due.pop_front();
         if (status !== g.status || blk !== g.blk || cell_idx !== g.cell_idx ||
             made !== g.made) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: status/block/cell/made expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        $realtime, g.status, g.blk, g.cell_idx, g.made,
                        status, blk, cell_idx, made);
         end
      endfunction
   endclass

   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = 1'b0;
   logic [REQ_W-1:0]  req_request_bytes = '0;
   logic [2:0]        req_free_block = '0;
   logic [CELL_W-1:0] req_free_cell = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [1:0]        rsp_status;
   logic [2:0]        rsp_got_block;
   logic [CELL_W-1:0] rsp_got_cell;
   logic              rsp_made_block;

   cell_ledger        ledger = new();
   cell_ref_type      live_cells [$];
   bit                steady = 1'b0;
   int unsigned       quiet_cycles = 0;

   size_class_cell_allocator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_request_bytes (req_request_bytes),
      .req_free_block    (req_free_block),
      .req_free_cell     (req_free_cell),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_got_block     (rsp_got_block),
      .rsp_got_cell      (rsp_got_cell),
      .rsp_made_block    (rsp_made_block)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         ledger.check_grant(rsp_status, rsp_got_block, rsp_got_cell, rsp_made_block);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Call at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(req_mode_type mode, logic [REQ_W-1:0] bytes, logic [2:0] fb,
                            logic [7:0] fc);
      grant_type g;
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= mode;
      req_request_bytes <= bytes;
      req_free_block    <= fb;
      req_free_cell     <= fc;
      do @(posedge clock); while (!req_ready);
      g = ledger.note_request(mode, bytes, fb, fc);
      if (mode == MODE_ALLOC && g.status == STATUS_OK)
         live_cells.push_back(cell_ref_type'{g.blk, g.cell_idx});
      @(negedge clock);
   endtask

   task automatic alloc(logic [REQ_W-1:0] bytes);
      send_item(MODE_ALLOC, bytes, 3'd0, 8'd0);
   endtask

   task automatic release_cell(logic [2:0] fb, logic [7:0] fc);
      send_item(MODE_FREE, '0, fb, fc);
   endtask

   task automatic random_item();
      int unsigned       pick;
      int unsigned       sz;
      int unsigned       idx;
      logic [REQ_W-1:0]  bytes;
      cell_ref_type      ref_cell;
      pick = $urandom_range(0, 99);
      if (pick >= 45 && pick < 85 && live_cells.size() != 0) begin
         // well-formed free of a cell currently handed out
         idx      = $urandom_range(0, live_cells.size() - 1);
         ref_cell = live_cells[idx];
         live_cells.delete(idx);
         send_item(MODE_FREE, REQ_W'($urandom), ref_cell.blk, ref_cell.cell_idx);
      end else if (pick >= 85) begin
         send_item(MODE_FREE, REQ_W'($urandom), 3'($urandom_range(0, 7)),
                   8'($urandom_range(0, 255)));
      end else begin
         sz = $urandom_range(0, 99);
         if (sz < 60)      bytes = REQ_W'($urandom_range(1, 64));
         else if (sz < 85) bytes = REQ_W'($urandom_range(65, BLOCK_BYTES));
         else if (sz < 90) bytes = '0;
         else              bytes = REQ_W'($urandom_range(BLOCK_BYTES + 1, 8191));
         send_item(MODE_ALLOC, bytes, 3'($urandom_range(0, 7)),
                   8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      alloc(13'd0);
      alloc(13'd1);
      alloc(13'd16);
      alloc(13'd4096);
      alloc(13'd4096);
      alloc(13'd4097);
      alloc(13'd8191);
      release_cell(3'd1, 8'd0);
      release_cell(3'd1, 8'd1);
      release_cell(3'd7, 8'd0);
      // cell never handed out goes onto the list all the same
      release_cell(3'd0, 8'd255);
      release_cell(3'd0, 8'd1);
      alloc(13'd5);
      alloc(13'd5);
      alloc(13'd5);
      release_cell(3'd0, 8'd3);
      release_cell(3'd0, 8'd3);
      alloc(13'd8);
      alloc(13'd8);
      alloc(13'd4000);
      alloc(13'd17);
      alloc(13'd300);
      alloc(13'd1000);
      alloc(13'd2000);
      alloc(13'd2049);
      alloc(13'd4096);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         steady = (i >= 150 && i < 350);
         if (i == 500) begin
            // hold off until the block has drained
            req_valid <= 1'b0;
            do @(negedge clock); while (ledger.pending() != 0);
         end
         random_item();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
